FILE: src/tmu_pkg.sv
// Shared types and constants for the multichannel trimmed mean unit.
// No dependencies; every other file imports this package.
package tmu_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int NUM_FIELDS = 5;
    localparam int GROUP_N    = 8;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Stage enables for the result pipeline, one per register stage.
    typedef struct packed {
        logic snap;
        logic grp;
        logic tot;
        logic mul;
        logic out;
    } pipe_ctl_t;

endpackage

FILE: src/tmu_sort_row.sv
// One channel's window, held in ascending order by insertion on every word.
// Depends on tmu_pkg.
module tmu_sort_row
    import tmu_pkg::*;
#(
    parameter int SAMPLES = 8,
    parameter int CNT_W   = 3
)
(
    input  logic                               clk,
    input  logic                               en,
    input  logic [CNT_W-1:0]                   cnt,
    input  sample_t                            x,
    output logic [SAMPLES-1:0][SAMPLE_W-1:0]   row_next
);

    logic [SAMPLES-1:0][SAMPLE_W-1:0] row_reg;
    logic [SAMPLES-1:0]               gt;

    always_comb
    begin
        for (int i = 0; i < SAMPLES; i++)
        begin
            gt[i] = (CNT_W'(i) < cnt) && (row_reg[i] > x);
        end
        // Entries above x shift up one place; x lands at the first such spot.
        for (int i = 0; i < SAMPLES; i++)
        begin
            if (i > 0 && gt[i-1])
            begin
                row_next[i] = row_reg[i-1];
            end
            else if (gt[i] || CNT_W'(i) >= cnt)
            begin
                row_next[i] = x;
            end
            else
            begin
                row_next[i] = row_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
        end
    end

endmodule

FILE: src/tmu_trim_sum.sv
// Snapshot of a full sorted window and the sum of its kept middle entries.
// Sums groups of eight in one stage, then the group sums in the next. Depends on tmu_pkg.
module tmu_trim_sum
    import tmu_pkg::*;
#(
    parameter int SAMPLES = 8,
    parameter int TRIM    = 2,
    parameter int SUM_W   = 15
)
(
    input  logic                               clk,
    input  pipe_ctl_t                          ctl,
    input  logic [SAMPLES-1:0][SAMPLE_W-1:0]   row,
    output logic [SUM_W-1:0]                   sum
);

    localparam int KEEP   = SAMPLES - 2 * TRIM;
    localparam int NGRP   = (KEEP + GROUP_N - 1) / GROUP_N;
    localparam int GSUM_W = SAMPLE_W + $clog2(GROUP_N + 1);

    logic [SAMPLES-1:0][SAMPLE_W-1:0] snap_reg;
    logic [NGRP-1:0][GSUM_W-1:0]      grp_reg;
    logic [NGRP-1:0][GSUM_W-1:0]      grp_next;
    logic [SUM_W-1:0]                 total_reg;
    logic [SUM_W-1:0]                 total_next;

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_N; k++)
            begin
                if (g * GROUP_N + k < KEEP)
                begin
                    grp_next[g] = grp_next[g]
                                + GSUM_W'(snap_reg[TRIM + g * GROUP_N + k]);
                end
            end
        end
        total_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total_next = total_next + SUM_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.snap)
        begin
            snap_reg <= row;
        end
        if (ctl.grp)
        begin
            grp_reg <= grp_next;
        end
        if (ctl.tot)
        begin
            total_reg <= total_next;
        end
    end

    assign sum = total_reg;

endmodule

FILE: src/tmu_const_div.sv
// Truncating division of the kept sum by a fixed divisor: reciprocal multiply,
// then one remainder compare that adds one to fix the estimate. Depends on tmu_pkg.
module tmu_const_div
    import tmu_pkg::*;
#(
    parameter int DIVISOR = 4,
    parameter int SUM_W   = 15,
    parameter int DIV_W   = 4
)
(
    input  logic             clk,
    input  pipe_ctl_t        ctl,
    input  logic [SUM_W-1:0] sum,
    output sample_t          mean
);

    localparam int                 RECIP_W = SUM_W + 1;
    localparam int                 PROD_W  = SUM_W + SUM_W;
    localparam int                 CHK_W   = SUM_W + DIV_W;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << SUM_W) / DIVISOR);

    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_d_reg;
    logic [SUM_W-1:0]  q_est;
    logic [CHK_W-1:0]  rem;
    logic [SUM_W-1:0]  quot;
    sample_t           mean_reg;

    always_comb
    begin
        // Estimate is exact or one low, since the reciprocal is rounded down.
        q_est = prod_reg[PROD_W-1 -: SUM_W];
        rem   = CHK_W'(sum_d_reg) - CHK_W'(q_est) * CHK_W'(DIVISOR);
        quot  = (rem >= CHK_W'(DIVISOR)) ? q_est + SUM_W'(1) : q_est;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg  <= PROD_W'(sum) * PROD_W'(RECIP);
            sum_d_reg <= sum;
        end
        if (ctl.out)
        begin
            mean_reg <= quot[SAMPLE_W-1:0];
        end
    end

    assign mean = mean_reg;

endmodule

FILE: src/multichannel_trimmed_mean_unit.sv
// Top level of the multichannel trimmed mean unit: round counter, result pipeline control.
// Depends on tmu_pkg, tmu_sort_row, tmu_trim_sum, tmu_const_div.
//
// Usage:
//   Input: one sampling round (sample_ch0..sample_ch4) is taken at each rising edge
//   with start high and busy low. busy is always low, so a round can be
//   given in every cycle.
//   Each channel's window is kept sorted as rounds arrive: one insertion per
//   round in a row of compare-and-shift registers.
//   The round that fills the window (every SAMPLES-th round) yields one result:
//   done is high for one cycle with mean_ch0..mean_ch4 valid, once that round
//   has passed the registered stages (snapshot at the edge that took it, then
//   group sums, total, reciprocal multiply, correction); the word is accepted
//   at the edge that samples done high. The window restarts at once.
//   Channels at or above CHANNELS, and all channels when 2*TRIM >= SAMPLES,
//   report zero.
//   Reset clears the round count and the result pipeline control; window contents
//   need no clearing. The receiver cannot stall: done is a one-cycle strobe.
module multichannel_trimmed_mean_unit
    import tmu_pkg::*;
#(
    parameter int SAMPLES  = 8,
    parameter int TRIM     = 2,
    parameter int CHANNELS = 5
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  sample_t sample_ch0,
    input  sample_t sample_ch1,
    input  sample_t sample_ch2,
    input  sample_t sample_ch3,
    input  sample_t sample_ch4,
    output logic    done,
    output sample_t mean_ch0,
    output sample_t mean_ch1,
    output sample_t mean_ch2,
    output sample_t mean_ch3,
    output sample_t mean_ch4
);

    localparam int KEEP  = (SAMPLES > 2 * TRIM) ? SAMPLES - 2 * TRIM : 0;
    localparam int CNT_W = $clog2(SAMPLES);
    localparam int DIV_W = $clog2(SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + DIV_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [3:0]       pipe_reg;
    logic             done_reg;
    logic             accept;
    logic             fire;
    pipe_ctl_t        ctl;
    sample_t          in_vec [NUM_FIELDS];
    sample_t          mean_vec [NUM_FIELDS];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign fire   = accept && (count_reg == CNT_W'(SAMPLES - 1));

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            count_next = '0;
        end
        else if (accept)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pipe_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pipe_reg  <= {pipe_reg[2:0], fire};
            done_reg  <= pipe_reg[3];
        end
    end

    assign ctl.snap = fire;
    assign ctl.grp  = pipe_reg[0];
    assign ctl.tot  = pipe_reg[1];
    assign ctl.mul  = pipe_reg[2];
    assign ctl.out  = pipe_reg[3];

    assign in_vec[0] = sample_ch0;
    assign in_vec[1] = sample_ch1;
    assign in_vec[2] = sample_ch2;
    assign in_vec[3] = sample_ch3;
    assign in_vec[4] = sample_ch4;

    for (genvar c = 0; c < NUM_FIELDS; c++)
    begin : g_ch
        if (c < CHANNELS && KEEP > 0)
        begin : g_live
            logic [SAMPLES-1:0][SAMPLE_W-1:0] row_next;
            logic [SUM_W-1:0]                 sum;

            tmu_sort_row #(
                .SAMPLES (SAMPLES),
                .CNT_W   (CNT_W)
            ) u_sort (
                .clk      (clk),
                .en       (accept),
                .cnt      (count_reg),
                .x        (in_vec[c]),
                .row_next (row_next)
            );

            tmu_trim_sum #(
                .SAMPLES (SAMPLES),
                .TRIM    (TRIM),
                .SUM_W   (SUM_W)
            ) u_sum (
                .clk (clk),
                .ctl (ctl),
                .row (row_next),
                .sum (sum)
            );

            tmu_const_div #(
                .DIVISOR (KEEP),
                .SUM_W   (SUM_W),
                .DIV_W   (DIV_W)
            ) u_div (
                .clk  (clk),
                .ctl  (ctl),
                .sum  (sum),
                .mean (mean_vec[c])
            );
        end
        else
        begin : g_off
            assign mean_vec[c] = '0;
        end
    end

    assign done     = done_reg;
    assign mean_ch0 = mean_vec[0];
    assign mean_ch1 = mean_vec[1];
    assign mean_ch2 = mean_vec[2];
    assign mean_ch3 = mean_vec[3];
    assign mean_ch4 = mean_vec[4];

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for multichannel_trimmed_mean_unit: drives sampling rounds and checks every mean word.
// Depends on tmu_pkg and the unit itself; a built-in window model predicts the results.
module tb;
    import tmu_pkg::*;

    localparam int P_SAMPLES  = 8;
    localparam int P_TRIM     = 2;
    localparam int P_CHANNELS = 5;
    localparam int LATENCY    = 5;
    localparam int RAND_ROUNDS = 826;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] chan_vec_t;

    typedef struct packed {
        chan_vec_t samp;
        logic      typed;
        chan_vec_t means;
    } dir_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    sample_t sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4;
    logic    done;
    sample_t mean_ch0, mean_ch1, mean_ch2, mean_ch3, mean_ch4;

    // window model
    sample_t   win_store [NUM_FIELDS][P_SAMPLES];
    int        win_fill;
    chan_vec_t pending_means [$];

    dir_row_t    dir_tab [24];
    int unsigned err_count;
    int unsigned rounds_sent;
    int unsigned words_checked;
    int unsigned cycle_count;
    chan_vec_t   got_v;
    chan_vec_t   want_v;

    multichannel_trimmed_mean_unit #(
        .SAMPLES  (P_SAMPLES),
        .TRIM     (P_TRIM),
        .CHANNELS (P_CHANNELS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample_ch0 (sample_ch0),
        .sample_ch1 (sample_ch1),
        .sample_ch2 (sample_ch2),
        .sample_ch3 (sample_ch3),
        .sample_ch4 (sample_ch4),
        .done       (done),
        .mean_ch0   (mean_ch0),
        .mean_ch1   (mean_ch1),
        .mean_ch2   (mean_ch2),
        .mean_ch3   (mean_ch3),
        .mean_ch4   (mean_ch4)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Sort one channel of the window, drop the extremes, average the rest.
    function automatic sample_t chan_trim_avg(input int c);
        sample_t     srt [P_SAMPLES];
        sample_t     t;
        int          i;
        int          j;
        logic [31:0] acc;
        int          keep;
        keep = P_SAMPLES - 2 * P_TRIM;
        if (c >= P_CHANNELS || keep <= 0)
            return '0;
        for (i = 0; i < P_SAMPLES; i++)
        begin
            t = win_store[c][i];
            j = i;
            while (j > 0 && srt[j-1] > t)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = t;
        end
        acc = '0;
        for (i = P_TRIM; i < P_TRIM + keep; i++)
            acc += 32'(srt[i]);
        return sample_t'(acc / keep);
    endfunction

    // Store one round; return 1 with the means when it completes the window.
    function automatic logic window_push(input chan_vec_t s, output chan_vec_t m);
        int c;
        m = '0;
        if (win_fill >= P_SAMPLES)
            win_fill = 0;
        for (c = 0; c < NUM_FIELDS && c < P_CHANNELS; c++)
            win_store[c][win_fill] = s[c];
        win_fill++;
        if (win_fill < P_SAMPLES)
            return 1'b0;
        for (c = 0; c < NUM_FIELDS; c++)
            m[c] = chan_trim_avg(c);
        win_fill = 0;
        return 1'b1;
    endfunction

    function automatic dir_row_t mk(input int a, input int b, input int c, input int d,
                                    input int e, input logic typed, input int ev);
        dir_row_t r;
        r.samp  = {sample_t'(e), sample_t'(d), sample_t'(c), sample_t'(b), sample_t'(a)};
        r.typed = typed;
        r.means = {NUM_FIELDS{sample_t'(ev)}};
        return r;
    endfunction

    function automatic sample_t pick_sample(input int mode);
        case (mode)
            3: return sample_t'($urandom_range(7));
            4: return sample_t'(4095 - $urandom_range(7));
            5:
            begin
                case ($urandom_range(3))
                    0: return 12'h000;
                    1: return 12'hFFF;
                    2: return 12'h800;
                    default: return 12'h7FF;
                endcase
            end
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Offer one round and hold it until taken; typed means override the model.
    task automatic send_round(input chan_vec_t s, input logic typed, input chan_vec_t tm);
        chan_vec_t m;
        start      <= 1'b1;
        sample_ch0 <= s[0];
        sample_ch1 <= s[1];
        sample_ch2 <= s[2];
        sample_ch3 <= s[3];
        sample_ch4 <= s[4];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        rounds_sent++;
        if (window_push(s, m))
            pending_means.push_back(typed ? tm : m);
    endtask

    // Drop start for a random stretch and put noise on the sample lines.
    task automatic idle_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start      <= 1'b0;
            sample_ch0 <= sample_t'($urandom);
            sample_ch1 <= sample_t'($urandom);
            sample_ch2 <= sample_t'($urandom);
            sample_ch3 <= sample_t'($urandom);
            sample_ch4 <= sample_t'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < pct)
                @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            got_v = {mean_ch4, mean_ch3, mean_ch2, mean_ch1, mean_ch0};
            if (pending_means.size() == 0)
            begin
                $error("unexpected mean word: %h", got_v);
                err_count++;
            end
            else
            begin
                want_v = pending_means.pop_front();
                words_checked++;
                for (int c = 0; c < NUM_FIELDS; c++)
                begin
                    if (got_v[c] !== want_v[c])
                    begin
                        $error("mean_ch%0d: expected %0d, got %0d", c, want_v[c], got_v[c]);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        chan_vec_t s;
        int        mode;
        int        pct;
        int        ph;
        int        n;
        cycle_count   = 0;
        err_count     = 0;
        rounds_sent   = 0;
        words_checked = 0;
        win_fill      = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        sample_ch0 = '0;
        sample_ch1 = '0;
        sample_ch2 = '0;
        sample_ch3 = '0;
        sample_ch4 = '0;

        // all-zero window, all-max window, then a mixed window with ties
        dir_tab[0]  = mk(0, 0, 0, 0, 0, 1'b0, 0);
        dir_tab[1]  = mk(0, 0, 0, 0, 0, 1'b0, 0);
        dir_tab[2]  = mk(0, 0, 0, 0, 0, 1'b0, 0);
        dir_tab[3]  = mk(0, 0, 0, 0, 0, 1'b0, 0);
        dir_tab[4]  = mk(0, 0, 0, 0, 0, 1'b0, 0);
        dir_tab[5]  = mk(0, 0, 0, 0, 0, 1'b0, 0);
        dir_tab[6]  = mk(0, 0, 0, 0, 0, 1'b0, 0);
        dir_tab[7]  = mk(0, 0, 0, 0, 0, 1'b1, 0);
        dir_tab[8]  = mk(4095, 4095, 4095, 4095, 4095, 1'b0, 0);
        dir_tab[9]  = mk(4095, 4095, 4095, 4095, 4095, 1'b0, 0);
        dir_tab[10] = mk(4095, 4095, 4095, 4095, 4095, 1'b0, 0);
        dir_tab[11] = mk(4095, 4095, 4095, 4095, 4095, 1'b0, 0);
        dir_tab[12] = mk(4095, 4095, 4095, 4095, 4095, 1'b0, 0);
        dir_tab[13] = mk(4095, 4095, 4095, 4095, 4095, 1'b0, 0);
        dir_tab[14] = mk(4095, 4095, 4095, 4095, 4095, 1'b0, 0);
        dir_tab[15] = mk(4095, 4095, 4095, 4095, 4095, 1'b1, 4095);
        dir_tab[16] = mk(0,    4095, 7, 0,    12'hAAA, 1'b0, 0);
        dir_tab[17] = mk(1,    4094, 7, 4095, 12'h555, 1'b0, 0);
        dir_tab[18] = mk(2,    4093, 7, 0,    12'hFFF, 1'b0, 0);
        dir_tab[19] = mk(4095, 3,    7, 4095, 12'h000, 1'b0, 0);
        dir_tab[20] = mk(4094, 2,    7, 0,    12'h800, 1'b0, 0);
        dir_tab[21] = mk(4093, 1,    7, 4095, 12'h001, 1'b0, 0);
        dir_tab[22] = mk(2048, 0,    7, 0,    12'h7FE, 1'b0, 0);
        dir_tab[23] = mk(2047, 4095, 7, 4095, 12'h123, 1'b0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_round(dir_tab[i].samp, dir_tab[i].typed, dir_tab[i].means);
        drain();

        // idling phases: none, heavy, light, none
        mode = 0;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1: pct = 69;
                2: pct = 13;
                default: pct = 0;
            endcase
            for (n = 0; n < RAND_ROUNDS / 4; n++)
            begin
                if (win_fill == 0 || win_fill >= P_SAMPLES)
                    mode = $urandom_range(5);
                for (int c = 0; c < NUM_FIELDS; c++)
                    s[c] = pick_sample(mode);
                send_round(s, 1'b0, '0);
                // hold off mid-phase until every pending mean has come out
                if (ph == 1 && n == RAND_ROUNDS / 8)
                    drain();
                else
                    idle_gap(pct);
            end
            drain();
        end

        if (pending_means.size() != 0)
        begin
            $error("%0d mean words never arrived", pending_means.size());
            err_count++;
        end
        $display("Sent %0d sampling rounds (directed extremes, ties, four idling phases);",
                 rounds_sent);
        $display("checked %0d mean words across %0d channels.", words_checked, NUM_FIELDS);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
